// File: hw/rtl/mcqm_pkg.sv
package mcqm_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_CHANNELS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF  = 8;
    localparam int MSG_WIDTH_DEF    = 64;

    // Fixed port widths
    localparam int CMD_W      = 2;
    localparam int CHAN_IN_W  = 8;
    localparam int CHAN_OUT_W = 4;
    localparam int MSG_PORT_W = 64;

    // Entries in the front-to-back op queue
    localparam int OPQ_ENTRIES = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_OPEN  = 2'd0,
        CMD_SEND  = 2'd1,
        CMD_RECV  = 2'd2,
        CMD_CLOSE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_CHANNEL = 3'd1,
        ST_NOT_OPEN    = 3'd2,
        ST_FULL        = 3'd3,
        ST_EMPTY       = 3'd4,
        ST_NO_FREE     = 3'd5
    } t_status;

    // Classified op handed from front to back
    typedef struct packed {
        logic                  ok;
        t_status               status;
        logic [CHAN_OUT_W-1:0] chan_out;
        logic                  is_write;
        logic                  is_read;
    } t_op_ctl;

endpackage

// File: hw/rtl/mcqm_front.sv
module mcqm_front #(
    parameter int NUM_CHANNELS = 16,
    parameter int QUEUE_DEPTH  = 8,
    parameter int MSG_WIDTH    = 64,
    parameter int ADDR_W       = 7
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [mcqm_pkg::CMD_W-1:0]         i_cmd,
    input  logic [mcqm_pkg::CHAN_IN_W-1:0]     i_channel,
    input  logic [mcqm_pkg::MSG_PORT_W-1:0]    i_message_in,
    input  logic                               i_q_full,
    output logic                               o_push,
    output mcqm_pkg::t_op_ctl                  o_ctl,
    output logic [ADDR_W-1:0]                  o_addr,
    output logic [MSG_WIDTH-1:0]               o_wdata
);
    import mcqm_pkg::*;

    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [NUM_CHANNELS-1:0] r_open;
    logic [PTR_W-1:0]        r_rptr [NUM_CHANNELS];
    logic [PTR_W-1:0]        r_wptr [NUM_CHANNELS];
    logic [CNT_W-1:0]        r_cnt  [NUM_CHANNELS];

    logic             acc;
    logic             free_found;
    logic [CH_W-1:0]  free_idx;
    logic             chv;
    logic [CH_W-1:0]  idx;
    logic             ch_open;
    logic [PTR_W-1:0] cur_rptr;
    logic [PTR_W-1:0] cur_wptr;
    logic [CNT_W-1:0] cur_cnt;
    logic [PTR_W-1:0] ptr_sel;
    logic [PTR_W-1:0] ptr_inc;
    logic             do_open;
    logic             do_send;
    logic             do_recv;
    logic             do_close;
    t_op_ctl          ctl;
    t_cmd             cmd;

    assign o_ready = !i_q_full;
    assign acc     = i_valid && o_ready;
    assign cmd     = t_cmd'(i_cmd);

    // Lowest free channel
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
            if (!r_open[i]) begin
                free_found = 1'b1;
                free_idx   = CH_W'(i);
            end
        end
    end

    assign chv      = ({1'b0, i_channel} < (CHAN_IN_W + 1)'(NUM_CHANNELS));
    assign idx      = i_channel[CH_W-1:0];
    assign ch_open  = chv && r_open[idx];
    assign cur_rptr = r_rptr[idx];
    assign cur_wptr = r_wptr[idx];
    assign cur_cnt  = r_cnt[idx];

    // Classify
    always_comb begin
        ctl      = '0;
        ctl.status = ST_OK;
        do_open  = 1'b0;
        do_send  = 1'b0;
        do_recv  = 1'b0;
        do_close = 1'b0;
        if (cmd == CMD_OPEN) begin
            if (free_found) begin
                do_open      = 1'b1;
                ctl.chan_out = CHAN_OUT_W'(free_idx);
            end else begin
                ctl.status = ST_NO_FREE;
            end
        end else if (!chv) begin
            ctl.status = ST_BAD_CHANNEL;
        end else if (!ch_open) begin
            ctl.status = ST_NOT_OPEN;
        end else begin
            case (cmd)
                CMD_SEND: begin
                    if (cur_cnt == CNT_W'(QUEUE_DEPTH)) begin
                        ctl.status = ST_FULL;
                    end else begin
                        do_send      = 1'b1;
                        ctl.is_write = 1'b1;
                    end
                end
                CMD_RECV: begin
                    if (cur_cnt == '0) begin
                        ctl.status = ST_EMPTY;
                    end else begin
                        do_recv     = 1'b1;
                        ctl.is_read = 1'b1;
                    end
                end
                CMD_CLOSE: begin
                    do_close = 1'b1;
                end
                default: begin
                    ctl.status = ST_OK;
                end
            endcase
        end
        ctl.ok = (ctl.status == ST_OK);
    end

    assign ptr_sel = do_send ? cur_wptr : cur_rptr;
    assign ptr_inc = (ptr_sel == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_sel + 1'b1;

    assign o_push  = acc;
    assign o_ctl   = ctl;
    assign o_addr  = ADDR_W'(ADDR_W'(idx) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(ptr_sel);
    assign o_wdata = i_message_in[MSG_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_rptr[i] <= '0;
                r_wptr[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else if (acc) begin
            if (do_open) begin
                r_open[free_idx] <= 1'b1;
                r_rptr[free_idx] <= '0;
                r_wptr[free_idx] <= '0;
                r_cnt[free_idx]  <= '0;
            end
            if (do_send) begin
                r_wptr[idx] <= ptr_inc;
                r_cnt[idx]  <= cur_cnt + 1'b1;
            end
            if (do_recv) begin
                r_rptr[idx] <= ptr_inc;
                r_cnt[idx]  <= cur_cnt - 1'b1;
            end
            if (do_close) begin
                r_open[idx] <= 1'b0;
                r_rptr[idx] <= '0;
                r_wptr[idx] <= '0;
                r_cnt[idx]  <= '0;
            end
        end
    end

    // A granted open marks the channel busy
    a_open_claims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && do_open) |=> r_open[$past(free_idx)])
        else $error("opened channel not marked busy");

    // Fill count of an addressed channel stays within depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && chv) |-> (cur_cnt <= CNT_W'(QUEUE_DEPTH)))
        else $error("fill count beyond queue depth");

    // Memory access only on a successful send or receive
    a_mem_op_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (ctl.is_write || ctl.is_read)) |-> (ctl.ok && ch_open && !(ctl.is_write && ctl.is_read)))
        else $error("memory op on failed command");

endmodule

// File: hw/rtl/mcqm_opq.sv
module mcqm_opq #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data
);
    import mcqm_pkg::*;

    localparam int IDX_W = (OPQ_ENTRIES > 1) ? $clog2(OPQ_ENTRIES) : 1;
    localparam int CNT_W = $clog2(OPQ_ENTRIES + 1);

    logic [DATA_W-1:0] r_slot [OPQ_ENTRIES];
    logic [IDX_W-1:0]  r_wr;
    logic [IDX_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_count;
    logic              do_pop;

    assign o_full  = (r_count == CNT_W'(OPQ_ENTRIES));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == IDX_W'(OPQ_ENTRIES - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == IDX_W'(OPQ_ENTRIES - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

// File: hw/rtl/mcqm_back.sv
module mcqm_back #(
    parameter int NUM_CHANNELS = 16,
    parameter int QUEUE_DEPTH  = 8,
    parameter int MSG_WIDTH    = 64,
    parameter int ADDR_W       = 7
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    output logic                               o_pop,
    input  mcqm_pkg::t_op_ctl                  i_ctl,
    input  logic [ADDR_W-1:0]                  i_addr,
    input  logic [MSG_WIDTH-1:0]               i_wdata,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_ok,
    output logic [2:0]                         o_status,
    output logic [mcqm_pkg::CHAN_OUT_W-1:0]    o_channel_out,
    output logic [mcqm_pkg::MSG_PORT_W-1:0]    o_message_out
);
    import mcqm_pkg::*;

    localparam int MEM_DEPTH = NUM_CHANNELS * QUEUE_DEPTH;

    logic [MSG_WIDTH-1:0] r_mem [MEM_DEPTH];
    logic [MSG_WIDTH-1:0] r_rdata;
    logic                 r_out_valid;
    t_op_ctl              r_ctl;
    logic                 pop;

    assign pop   = i_q_valid && (!r_out_valid || i_ready);
    assign o_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_ctl <= i_ctl;
        end
    end

    // Single-port message store, registered read
    always_ff @(posedge i_clk) begin
        if (pop && i_ctl.is_write) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (pop && i_ctl.is_read) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_ok          = r_ctl.ok;
    assign o_status      = r_ctl.status;
    assign o_channel_out = r_ctl.chan_out;
    assign o_message_out = r_ctl.is_read ? MSG_PORT_W'(r_rdata) : '0;

endmodule

// File: hw/rtl/multi_channel_queue_manager_top.sv
// Flow: a command accepted at the input is written into the op queue; the back pops it
//   into the output register once that register is empty or its result is being taken.
// Throughput: one command per cycle while the output is not stalled; the single-port
//   message store takes one access per command and is the unit that sets this figure.
// Reset (i_rst_n, synchronous, active low): all channels free, pointers and counts
//   zero, op queue and output register empty. Message store is not cleared.
module multi_channel_queue_manager_top #(
    parameter int NUM_CHANNELS = mcqm_pkg::NUM_CHANNELS_DEF,
    parameter int QUEUE_DEPTH  = mcqm_pkg::QUEUE_DEPTH_DEF,
    parameter int MSG_WIDTH    = mcqm_pkg::MSG_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [mcqm_pkg::CMD_W-1:0]         i_cmd,
    input  logic [mcqm_pkg::CHAN_IN_W-1:0]     i_channel,
    input  logic [mcqm_pkg::MSG_PORT_W-1:0]    i_message_in,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_ok,
    output logic [2:0]                         o_status,
    output logic [mcqm_pkg::CHAN_OUT_W-1:0]    o_channel_out,
    output logic [mcqm_pkg::MSG_PORT_W-1:0]    o_message_out
);
    import mcqm_pkg::*;

    // Store is NUM_CHANNELS rings of QUEUE_DEPTH words, channel-major.
    localparam int MEM_DEPTH = NUM_CHANNELS * QUEUE_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CTL_W     = $bits(t_op_ctl);
    localparam int OP_W      = CTL_W + ADDR_W + MSG_WIDTH;

    // Front -> queue
    logic                 f_push;
    t_op_ctl              f_ctl;
    logic [ADDR_W-1:0]    f_addr;
    logic [MSG_WIDTH-1:0] f_wdata;
    logic                 q_full;

    // Queue -> back
    logic                 q_valid;
    logic                 q_pop;
    logic [OP_W-1:0]      q_data;
    t_op_ctl              b_ctl;
    logic [ADDR_W-1:0]    b_addr;
    logic [MSG_WIDTH-1:0] b_wdata;

    // Front: checks channel state in flops, updates pointers/counts at transfer,
    // emits a classified op. Ready only depends on queue space.
    mcqm_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .MSG_WIDTH    (MSG_WIDTH),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_channel    (i_channel),
        .i_message_in (i_message_in),
        .i_q_full     (q_full),
        .o_push       (f_push),
        .o_ctl        (f_ctl),
        .o_addr       (f_addr),
        .o_wdata      (f_wdata)
    );

    // Short op queue decouples the two halves; order is kept, so memory
    // writes and reads land in command order.
    mcqm_opq #(
        .DATA_W (OP_W)
    ) u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_ctl, f_addr, f_wdata}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    assign b_ctl   = t_op_ctl'(q_data[OP_W-1 -: CTL_W]);
    assign b_addr  = q_data[MSG_WIDTH +: ADDR_W];
    assign b_wdata = q_data[MSG_WIDTH-1:0];

    // Back: message store access and the output register.
    mcqm_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .MSG_WIDTH    (MSG_WIDTH),
        .ADDR_W       (ADDR_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .o_pop         (q_pop),
        .i_ctl         (b_ctl),
        .i_addr        (b_addr),
        .i_wdata       (b_wdata),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_ok          (o_ok),
        .o_status      (o_status),
        .o_channel_out (o_channel_out),
        .o_message_out (o_message_out)
    );

endmodule
